>>> rtl/sstt_pkg.sv
// sstt_pkg: types, register indexes and helper functions for the single-step interval tuner
// no dependencies; imported by the channel interfaces and every module of the block
package sstt_pkg;

  localparam int unsigned TIME_W     = 25;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned INTERVAL_W = 16;
  localparam int unsigned STREAK_W   = 8;
  localparam int unsigned PARTIAL_W  = 5;
  localparam int unsigned CODE_W     = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [INTERVAL_W-1:0] RESET_BASE_INTERVAL = 16'd30;
  localparam logic [STREAK_W-1:0]   RESET_STREAK_LIMIT  = 8'd8;
  localparam logic [PARTIAL_W-1:0]  RESET_MAX_PARTIAL   = 5'd16;
  localparam logic [INTERVAL_W-1:0] INTERVAL_MAX        = 16'hFFFF;
  localparam logic [STREAK_W-1:0]   STREAK_MAX          = 8'hFF;
  localparam logic [PARTIAL_W-1:0]  PARTIAL_MAX         = 5'h1F;
  localparam logic [WORD_W-1:0]     UNIT_TIME           = 32'd1;

  // register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_BASE_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_STREAK_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_MAX_PARTIAL   = 2'd2;

  // mode codes as seen on the result channel
  localparam logic [CODE_W-1:0] MODE_CODE_ATOMIC    = 2'd0;
  localparam logic [CODE_W-1:0] MODE_CODE_RESUME    = 2'd1;
  localparam logic [CODE_W-1:0] MODE_CODE_RESUME_PC = 2'd2;
  localparam logic [CODE_W-1:0] MODE_CODE_RESTART   = 2'd3;

  typedef enum logic [3:0] {
    MODE_ATOMIC    = 4'b0001,
    MODE_RESUME    = 4'b0010,
    MODE_RESUME_PC = 4'b0100,
    MODE_RESTART   = 4'b1000
  } mode_t;

  typedef struct packed {
    logic [INTERVAL_W-1:0] base_interval;
    logic [STREAK_W-1:0]   streak_limit;
    logic [PARTIAL_W-1:0]  max_partial;
  } cfg_t;

  typedef struct packed {
    mode_t                 mode;
    mode_t                 prev_mode;
    logic [INTERVAL_W-1:0] interval;
    logic [STREAK_W-1:0]   streak_count;
    logic [PARTIAL_W-1:0]  partial_count;
    logic [INTERVAL_W-1:0] saved_resume_pc_interval;
    logic [INTERVAL_W-1:0] saved_restart_interval;
  } tuner_state_t;

  localparam tuner_state_t STATE_RESET = '{
    mode:                     MODE_ATOMIC,
    prev_mode:                MODE_ATOMIC,
    interval:                 RESET_BASE_INTERVAL,
    streak_count:             '0,
    partial_count:            '0,
    saved_resume_pc_interval: '0,
    saved_restart_interval:   '0
  };

  function automatic logic [INTERVAL_W-1:0] sat_inc16(input logic [INTERVAL_W-1:0] v);
    return (v == INTERVAL_MAX) ? v : v + 16'd1;
  endfunction

  function automatic logic [CODE_W-1:0] mode_code(input mode_t m);
    logic [CODE_W-1:0] c;
    unique case (m)
      MODE_ATOMIC:    c = MODE_CODE_ATOMIC;
      MODE_RESUME:    c = MODE_CODE_RESUME;
      MODE_RESUME_PC: c = MODE_CODE_RESUME_PC;
      MODE_RESTART:   c = MODE_CODE_RESTART;
      default:        c = MODE_CODE_ATOMIC;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/sstt_in_if.sv
// sstt_in_if: measurement channel, one instruction time per item
// depends on sstt_pkg
interface sstt_in_if import sstt_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [TIME_W-1:0] instr_time;

  modport source (output valid, output instr_time, input ready);
  modport sink (input valid, input instr_time, output ready);
endinterface

>>> rtl/sstt_out_if.sv
// sstt_out_if: result channel, next interval and next mode per item
// depends on sstt_pkg
interface sstt_out_if import sstt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [INTERVAL_W-1:0] next_interval;
  logic [CODE_W-1:0]     next_mode;

  modport source (output valid, output next_interval, output next_mode, input ready);
  modport sink (input valid, input next_interval, input next_mode, output ready);
endinterface

>>> rtl/sstt_cfg_if.sv
// sstt_cfg_if: configuration write channel, register index and write data
// depends on sstt_pkg
interface sstt_cfg_if import sstt_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/sstt_cfg_regs.sv
// sstt_cfg_regs: configuration register file, base interval, streak limit, partial limit
// depends on sstt_pkg and sstt_cfg_if
module sstt_cfg_regs import sstt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  sstt_cfg_if.sink   cfg_ch,
  output cfg_t       cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;

  assign cfg_ch.ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        CFG_IDX_BASE_INTERVAL: cfg_nxt.base_interval = cfg_ch.data;
        CFG_IDX_STREAK_LIMIT:  cfg_nxt.streak_limit = cfg_ch.data[STREAK_W-1:0];
        CFG_IDX_MAX_PARTIAL:   cfg_nxt.max_partial = cfg_ch.data[PARTIAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.base_interval <= RESET_BASE_INTERVAL;
      cfg_r.streak_limit <= RESET_STREAK_LIMIT;
      cfg_r.max_partial <= RESET_MAX_PARTIAL;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

>>> rtl/sstt_step.sv
// sstt_step: next-state logic of the four-mode interval controller for one item
// depends on sstt_pkg
module sstt_step import sstt_pkg::*; (
  input  cfg_t                     cfg,
  input  tuner_state_t             cur,
  input  logic signed [TIME_W-1:0] instr_time,
  output tuner_state_t             nxt
);

  logic [WORD_W-1:0]     t32;
  logic [WORD_W-1:0]     t_adj;
  logic [INTERVAL_W-1:0] excess;
  logic                  over_base;
  logic [INTERVAL_W-1:0] retry_src;
  logic [INTERVAL_W-1:0] retry_base;
  logic [INTERVAL_W-1:0] retry_int;
  logic [STREAK_W-1:0]   streak_tmp;

  assign t32       = WORD_W'(instr_time);
  assign over_base = cur.interval > cfg.base_interval;
  assign excess    = cur.interval - cfg.base_interval;
  // resume correction for the extra interval
  assign t_adj     = over_base ? t32 - {{(WORD_W-INTERVAL_W){1'b0}}, excess} : t32;

  assign retry_src  = (cur.mode == MODE_RESUME_PC) ? cur.saved_resume_pc_interval
                                                   : cur.saved_restart_interval;
  assign retry_base = (retry_src == '0) ? cur.interval : retry_src;
  assign retry_int  = sat_inc16(retry_base);

  always_comb begin
    nxt = cur;
    streak_tmp = cur.streak_count;
    unique case (cur.mode)
      MODE_ATOMIC: begin
        nxt.interval = cfg.base_interval;
        if (cur.prev_mode == MODE_ATOMIC) begin
          if (t32 == UNIT_TIME) begin
            if (cur.streak_count != STREAK_MAX) begin
              streak_tmp = cur.streak_count + 8'd1;
            end
          end else begin
            if (cur.streak_count != '0) begin
              nxt.saved_resume_pc_interval = '0;
            end
            streak_tmp = '0;
            nxt.saved_restart_interval = '0;
          end
        end
        if (streak_tmp >= cfg.streak_limit) begin
          nxt.streak_count = '0;
          nxt.mode = MODE_RESUME;
        end else begin
          nxt.streak_count = streak_tmp;
        end
        nxt.prev_mode = MODE_ATOMIC;
      end
      MODE_RESUME: begin
        if (t_adj == UNIT_TIME && cur.prev_mode == MODE_RESUME) begin
          nxt.partial_count = '0;
          nxt.mode = MODE_RESTART;
        end else if (cur.partial_count >= cfg.max_partial) begin
          nxt.partial_count = '0;
          nxt.mode = MODE_RESUME_PC;
        end else if (t_adj > UNIT_TIME) begin
          nxt.mode = MODE_ATOMIC;
        end else begin
          nxt.interval = sat_inc16(cur.interval);
          if (cur.partial_count != PARTIAL_MAX) begin
            nxt.partial_count = cur.partial_count + 5'd1;
          end
        end
        nxt.prev_mode = MODE_RESUME;
      end
      MODE_RESUME_PC: begin
        nxt.interval = retry_int;
        nxt.saved_resume_pc_interval = retry_int;
        nxt.mode = MODE_ATOMIC;
        nxt.prev_mode = MODE_RESUME_PC;
      end
      MODE_RESTART: begin
        nxt.interval = retry_int;
        nxt.saved_restart_interval = retry_int;
        nxt.mode = MODE_ATOMIC;
        nxt.prev_mode = MODE_RESTART;
      end
      default: nxt = cur;
    endcase
  end

endmodule

>>> rtl/single_step_interval_tuner_core.sv
// single_step_interval_tuner_core: top level of the single-step interval tuner
// depends on sstt_pkg, the three channel interfaces, sstt_cfg_regs and sstt_step
//
// usage:
//   in_ch carries one measured instruction time per item (25-bit signed, taken
//   after one timer interrupt). out_ch returns exactly one item per input item:
//   the interval to program for the next step and the controller mode
//   (0 atomic, 1 resume, 2 resume with PC, 3 restart).
//   cfg_ch writes base_interval (index 0), streak_limit (1), partial limit (2);
//   other indexes are ignored. cfg_ch is always ready; write only while idle.
//   path: an accepted item is held in the input register, decided from there
//   and loaded into the result register that drives out_ch once it is free or read.
//   throughput: one item per cycle when out_ch is ready; the controller update is
//   a single pass of compare and 32-bit subtract logic from input to result register.
//   stall: a stalled result holds in the result register while one more item
//   waits in the input register; in_ch.ready drops only when both are full.
//   reset (rst_n low, synchronous): registers return to their reset values,
//   mode atomic, interval 30, counters and saved intervals zero, both stages empty.
module single_step_interval_tuner_core import sstt_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  sstt_in_if.sink      in_ch,
  sstt_out_if.source   out_ch,
  sstt_cfg_if.sink     cfg_ch
);

  cfg_t                     cfg;
  tuner_state_t             state_r;
  tuner_state_t             state_nxt;
  logic                     in_vld_r;
  logic signed [TIME_W-1:0] in_time_r;
  logic                     out_vld_r;
  logic [INTERVAL_W-1:0]    out_interval_r;
  logic [CODE_W-1:0]        out_mode_r;
  logic                     advance;
  logic                     in_take;

  sstt_cfg_regs u_cfg_regs (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .cfg    (cfg)
  );

  sstt_step u_step (
    .cfg        (cfg),
    .cur        (state_r),
    .instr_time (in_time_r),
    .nxt        (state_nxt)
  );

  assign advance     = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || advance;
  assign in_take     = in_ch.valid && in_ch.ready;

  assign out_ch.valid         = out_vld_r;
  assign out_ch.next_interval = out_interval_r;
  assign out_ch.next_mode     = out_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      state_r   <= STATE_RESET;
    end else begin
      if (in_take) begin
        in_vld_r <= 1'b1;
      end else if (advance) begin
        in_vld_r <= 1'b0;
      end
      if (advance) begin
        out_vld_r <= 1'b1;
        state_r   <= state_nxt;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_time_r <= in_ch.instr_time;
    end
    if (advance) begin
      out_interval_r <= state_nxt.interval;
      out_mode_r     <= mode_code(state_nxt.mode);
    end
  end

  // input side blocks only when both stages hold an item and the result stalls
  a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (in_vld_r && out_vld_r && !out_ch.ready))
    else $error("input blocked without a full pipeline");

  // a decided item always lands in the result register
  a_advance_fills_out: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_vld_r)
    else $error("result register empty after an item was decided");

  // resume-with-PC and restart last one item and fall back to atomic
  a_retry_returns_atomic: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && (state_r.mode == MODE_RESUME_PC || state_r.mode == MODE_RESTART))
    |=> (state_r.mode == MODE_ATOMIC))
    else $error("retry mode did not return to atomic");

  // after an atomic step the streak stays below the limit or has been cleared
  a_streak_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && state_r.mode == MODE_ATOMIC)
    |=> (state_r.streak_count < $past(cfg.streak_limit) || state_r.streak_count == '0))
    else $error("streak count reached its limit without a mode change");

  // the result register mirrors the controller state it was loaded from
  a_out_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> (out_interval_r == state_r.interval && out_mode_r == mode_code(state_r.mode)))
    else $error("result differs from updated controller state");

endmodule

>>> test/single_step_interval_tuner_core_test.sv
// single_step_interval_tuner_core_test: self-checking bench for the interval tuner core
// predicts next interval and mode per measured time under random gaps, stalls and settings
// depends on sstt_pkg, the three channel interfaces and single_step_interval_tuner_core
module single_step_interval_tuner_core_test;
  import sstt_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 4;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_UNUSED = 2'd3;

  typedef struct packed {
    logic [INTERVAL_W-1:0] interval;
    logic [CODE_W-1:0]     mode;
  } decision_t;

  logic clk;
  logic rst_n;

  sstt_in_if  in_ch ();
  sstt_out_if out_ch ();
  sstt_cfg_if cfg_ch ();

  single_step_interval_tuner_core dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // predicted settings and controller state
  logic [INTERVAL_W-1:0] base_ivl;
  logic [STREAK_W-1:0]   stuck_limit;
  logic [PARTIAL_W-1:0]  partial_limit;
  logic [CODE_W-1:0]     cur_mode;
  logic [CODE_W-1:0]     last_mode;
  logic [INTERVAL_W-1:0] cur_ivl;
  logic [STREAK_W-1:0]   unit_streak;
  logic [PARTIAL_W-1:0]  resume_steps;
  logic [INTERVAL_W-1:0] pc_retry_ivl;
  logic [INTERVAL_W-1:0] restart_retry_ivl;

  decision_t expected_decisions[$];
  decision_t head_decision;
  int mismatch_count = 0;
  int cycle_count = 0;
  int in_gap_max = 6;
  int out_gap_max = 6;
  int grow_pct = 40;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("single_step_interval_tuner_core_test NOT OK");
      $finish;
    end
  end

  function automatic logic [INTERVAL_W-1:0] bump_interval(input logic [INTERVAL_W-1:0] v);
    return (v == 16'hFFFF) ? v : v + 16'd1;
  endfunction

  task automatic reset_tuner();
    base_ivl          = 16'd30;
    stuck_limit       = 8'd8;
    partial_limit     = 5'd16;
    cur_mode          = MODE_CODE_ATOMIC;
    last_mode         = MODE_CODE_ATOMIC;
    cur_ivl           = 16'd30;
    unit_streak       = '0;
    resume_steps      = '0;
    pc_retry_ivl      = '0;
    restart_retry_ivl = '0;
  endtask

  task automatic apply_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    case (idx)
      CFG_IDX_BASE_INTERVAL: base_ivl = data;
      CFG_IDX_STREAK_LIMIT:  stuck_limit = data[STREAK_W-1:0];
      CFG_IDX_MAX_PARTIAL:   partial_limit = data[PARTIAL_W-1:0];
      default: ;
    endcase
  endtask

  task automatic retry_step(inout logic [INTERVAL_W-1:0] saved, input logic [CODE_W-1:0] from);
    cur_ivl   = (saved == '0) ? bump_interval(cur_ivl) : bump_interval(saved);
    saved     = cur_ivl;
    cur_mode  = MODE_CODE_ATOMIC;
    last_mode = from;
  endtask

  task automatic tuner_step(input logic signed [TIME_W-1:0] t);
    logic [WORD_W-1:0] w;
    w = {{(WORD_W-TIME_W){t[TIME_W-1]}}, t};
    case (cur_mode)
      MODE_CODE_ATOMIC: begin
        cur_ivl = base_ivl;
        if (last_mode == MODE_CODE_ATOMIC) begin
          if (w == 32'd1) begin
            if (unit_streak != 8'hFF) unit_streak++;
          end else begin
            if (unit_streak != '0) pc_retry_ivl = '0;
            unit_streak       = '0;
            restart_retry_ivl = '0;
          end
        end
        if (unit_streak >= stuck_limit) begin
          unit_streak = '0;
          cur_mode    = MODE_CODE_RESUME;
        end
        last_mode = MODE_CODE_ATOMIC;
      end
      MODE_CODE_RESUME: begin
        if (cur_ivl > base_ivl) w = w - ({16'd0, cur_ivl} - {16'd0, base_ivl});
        if (w == 32'd1 && last_mode == MODE_CODE_RESUME) begin
          resume_steps = '0;
          cur_mode     = MODE_CODE_RESTART;
        end else if (resume_steps >= partial_limit) begin
          resume_steps = '0;
          cur_mode     = MODE_CODE_RESUME_PC;
        end else if (w > 32'd1) begin
          cur_mode = MODE_CODE_ATOMIC;
        end else begin
          cur_ivl = bump_interval(cur_ivl);
          if (resume_steps != 5'h1F) resume_steps++;
        end
        last_mode = MODE_CODE_RESUME;
      end
      MODE_CODE_RESUME_PC: retry_step(pc_retry_ivl, MODE_CODE_RESUME_PC);
      default: retry_step(restart_retry_ivl, MODE_CODE_RESTART);
    endcase
    expected_decisions.push_back('{interval: cur_ivl, mode: cur_mode});
  endtask

  // biased toward unit times and resume corrections that keep the controller moving
  function automatic logic signed [TIME_W-1:0] pick_time();
    logic [WORD_W-1:0] skew;
    int roll;
    int rest;
    roll = $urandom_range(0, 99);
    rest = (100 - grow_pct) / 3;
    skew = (cur_ivl > base_ivl) ? {16'd0, cur_ivl - base_ivl} : '0;
    case (cur_mode)
      MODE_CODE_ATOMIC: begin
        if (roll < 60) return TIME_W'(1);
        if (roll < 70) return TIME_W'($urandom_range(0, 2));
        if (roll < 80) return TIME_W'(0 - int'($urandom_range(1, 16)));
        return TIME_W'($urandom);
      end
      MODE_CODE_RESUME: begin
        if (roll < grow_pct) return TIME_W'(skew);
        if (roll < grow_pct + rest) return TIME_W'(skew + 32'd1);
        if (roll < grow_pct + 2 * rest) return TIME_W'(skew + 32'd2);
        return TIME_W'($urandom);
      end
      default: return TIME_W'($urandom);
    endcase
  endfunction

  task automatic send_time(input logic signed [TIME_W-1:0] t);
    int gap;
    gap = $urandom_range(0, in_gap_max);
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid      <= 1'b1;
    in_ch.instr_time <= t;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    tuner_step(t);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    apply_reg(idx, data);
  endtask

  task automatic configure(input logic [CFG_DATA_W-1:0] base, input logic [CFG_DATA_W-1:0] streak,
                           input logic [CFG_DATA_W-1:0] partial);
    write_reg(CFG_IDX_BASE_INTERVAL, base);
    write_reg(CFG_IDX_STREAK_LIMIT, streak);
    write_reg(CFG_IDX_MAX_PARTIAL, partial);
    write_reg(CFG_IDX_UNUSED, CFG_DATA_W'($urandom));
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (expected_decisions.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic test_field_extremes();
    logic signed [TIME_W-1:0] seq [19] = '{
      25'h0FFFFFF, 25'h1000000, 25'h1FFFFFF, 25'h0000000, 25'h0000002,
      25'h0000001, 25'h0000001, 25'h0000001, 25'h0000001,
      25'h0000001, 25'h0000001, 25'h0000001, 25'h0000001,
      25'h0000000, 25'h0000001, 25'h0000003, 25'h0AAAAAA, 25'h1555555, 25'h0000001
    };
    foreach (seq[i]) send_time(seq[i]);
    settle();
  endtask

  task automatic test_zero_registers();
    configure(16'd0, 16'hFF00, 16'hFFE0);
    repeat (20) send_time(pick_time());
    settle();
  endtask

  task automatic test_interval_saturation();
    configure(16'd65533, 16'd1, 16'd31);
    grow_pct = 85;
    repeat (80) send_time(pick_time());
    settle();
    grow_pct = 40;
  endtask

  task automatic test_stuck_instruction();
    configure(16'd30, {8'($urandom), 8'd255}, {11'($urandom), 5'd16});
    in_gap_max = 1;
    repeat (260) send_time(TIME_W'(1));
    in_gap_max = 6;
    repeat (20) send_time(pick_time());
    settle();
  endtask

  task automatic test_random_settings();
    logic [CFG_DATA_W-1:0] base;
    logic [STREAK_W-1:0]   streak;
    logic [PARTIAL_W-1:0]  partial;
    for (int phase = 0; phase < 7; phase++) begin
      case ($urandom_range(0, 5))
        0: base = 16'd0;
        1: base = 16'd1;
        2: base = 16'd30;
        3: base = 16'hFFFF;
        4: base = 16'hFFFF - 16'($urandom_range(1, 40));
        default: base = 16'($urandom);
      endcase
      case ($urandom_range(0, 5))
        0: streak = 8'd0;
        1: streak = 8'd1;
        2: streak = 8'd2;
        3: streak = 8'd255;
        default: streak = 8'($urandom_range(3, 12));
      endcase
      case ($urandom_range(0, 4))
        0: partial = 5'd0;
        1: partial = 5'd1;
        2: partial = 5'd31;
        default: partial = 5'($urandom_range(2, 16));
      endcase
      if (phase == 6) begin
        base    = 16'd30;
        streak  = 8'd8;
        partial = 5'd16;
      end
      configure(base, {8'($urandom), streak}, {11'($urandom), partial});
      in_gap_max  = ($urandom_range(0, 3) == 0) ? 0 : 6;
      out_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 6;
      repeat (140) send_time(pick_time());
      settle();
    end
    in_gap_max  = 6;
    out_gap_max = 6;
  endtask

  // result side: random stall before each item
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    forever begin
      gap = $urandom_range(0, out_gap_max);
      repeat (gap) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      @(posedge clk);
      while (!(rst_n && out_ch.valid)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_decisions.size() == 0) begin
        if (mismatch_count < 10)
          $display("unexpected item: interval %0d mode %0d",
                   out_ch.next_interval, out_ch.next_mode);
        mismatch_count++;
      end else begin
        head_decision = expected_decisions.pop_front();
        if (out_ch.next_interval !== head_decision.interval ||
            out_ch.next_mode !== head_decision.mode) begin
          if (mismatch_count < 10)
            $display("mismatch: interval %0d mode %0d, expected interval %0d mode %0d",
                     out_ch.next_interval, out_ch.next_mode,
                     head_decision.interval, head_decision.mode);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    rst_n            = 1'b0;
    in_ch.valid      = 1'b0;
    in_ch.instr_time = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = '0;
    cfg_ch.data      = '0;
    reset_tuner();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_field_extremes();
    test_zero_registers();
    test_interval_saturation();
    test_stuck_instruction();
    test_random_settings();

    if (mismatch_count == 0) begin
      $display("single_step_interval_tuner_core_test OK");
    end else begin
      $display("single_step_interval_tuner_core_test NOT OK");
    end
    $finish;
  end

endmodule
